@@ hdl/dual_wheel_speed_period_meter_top_defines.svh @@
// Assertion macros used by the checker file.
`ifndef DUAL_WHEEL_SPEED_PERIOD_METER_TOP_DEFINES_SVH
`define DUAL_WHEEL_SPEED_PERIOD_METER_TOP_DEFINES_SVH

// Same-cycle implication, off during reset.
`define DWSP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dwsp assertion failed");

// Next-cycle implication, off during reset.
`define DWSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dwsp assertion failed");

// Same-cycle implication that is also checked during reset.
`define DWSP_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("dwsp assertion failed");

`endif

@@ hdl/dwsp_pkg.sv @@
package dwsp_pkg;

  localparam int TS_BITS_DEFAULT = 32;
  localparam int EXT_W           = 64;   // widest timestamp supported

  localparam int CMD_W     = 2;
  localparam int NOW_W     = 32;
  localparam int SPEED_W   = 8;
  localparam int NUM_W     = 20;
  localparam int TEETH_W   = 8;
  localparam int STOP_W    = 16;
  localparam int PERIOD_W  = 16;
  localparam int DIVISOR_W = TEETH_W + PERIOD_W;
  localparam int CMP_W     = DIVISOR_W + SPEED_W;
  localparam int CNT_W     = $clog2(SPEED_W + 1);

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [CMD_W-1:0] CMD_LEFT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RIGHT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SPEED = 2'd2;

  localparam logic [1:0] REG_NUM   = 2'd0;
  localparam logic [1:0] REG_TEETH = 2'd1;
  localparam logic [1:0] REG_STOP  = 2'd2;

  localparam logic [NUM_W-1:0]   NUM_RESET   = 20'd100000;
  localparam logic [TEETH_W-1:0] TEETH_RESET = 8'd16;
  localparam logic [STOP_W-1:0]  STOP_RESET  = 16'd1250;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [NUM_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [SPEED_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ hdl/dwsp_if.sv @@
interface dwsp_in_if;
  import dwsp_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [NOW_W-1:0] now;

  modport source (output valid, output cmd, output now, input ready);
  modport sink (input valid, input cmd, input now, output ready);
endinterface

interface dwsp_out_if;
  import dwsp_pkg::*;
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed_left;
  logic [SPEED_W-1:0] speed_right;

  modport source (output valid, output speed_left, output speed_right, input ready);
  modport sink (input valid, input speed_left, input speed_right, output ready);
endinterface

@@ hdl/dwsp_div.sv @@
// Saturating 8-bit restoring divider, one compare/subtract per cycle.
module dwsp_div (
  input  logic               clk,
  input  logic               rst,
  input  dwsp_pkg::div_req_t ctl,
  output dwsp_pkg::div_rsp_t stat
);
  import dwsp_pkg::*;

  logic                 busy;
  logic                 done;
  logic [NUM_W-1:0]     rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [CNT_W-1:0]     cnt;
  logic [SPEED_W-1:0]   quot;

  logic [CMP_W-1:0] shifted;
  logic [CMP_W:0]   diff;
  logic             fits;

  // the shared unit: divisor shifted by the bit position, one subtract
  assign shifted = CMP_W'(dvs) << cnt;
  assign diff    = {1'b0, CMP_W'(rem)} - {1'b0, shifted};
  assign fits    = ~diff[CMP_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        rem  <= ctl.dividend;
        dvs  <= ctl.divisor;
        cnt  <= CNT_W'(SPEED_W);
        quot <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(SPEED_W)) begin
          // quotient would not fit in SPEED_W bits: saturate
          if (fits) begin
            quot <= '1;
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else begin
          if (fits) begin
            rem <= diff[NUM_W-1:0];
            quot[cnt[$clog2(SPEED_W)-1:0]] <= 1'b1;
          end
          if (cnt == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign stat.done = done;
  assign stat.quot = quot;

endmodule

@@ hdl/dual_wheel_speed_period_meter_top.sv @@
// Channel  Dir  Fields                    Transaction
// req      in   cmd[1:0], now[31:0]       valid & ready at rising clk
// rsp      out  speed_left, speed_right   valid & ready at rising clk
// apb      in   paddr[3:0], pwdata[31:0]  psel & penable & pwrite
//
// Edge commands (left/right) and unused codes stay in ST_IDLE; ready stays high.
// A speed request holds ready low: per wheel a multiply state, a start state and,
// for a period in range, a divider run to done or saturation; then an output load state.
// A full output register parks a new speed request in ST_OUT until the slot frees;
// ready stays low while it waits there, so edge transactions wait as well.
// rst is synchronous, active high; restores register defaults, clears edges, periods, valid.
module dual_wheel_speed_period_meter_top #(
  parameter int TIMESTAMP_BITS = dwsp_pkg::TS_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dwsp_pkg::APB_AW-1:0] paddr,
  input  logic [dwsp_pkg::APB_DW-1:0] pwdata,
  output logic [dwsp_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  dwsp_in_if.sink                     req,
  dwsp_out_if.source                  rsp
);
  import dwsp_pkg::*;

  // configuration
  logic [NUM_W-1:0]   speed_numerator;
  logic [TEETH_W-1:0] teeth_per_rev;
  logic [STOP_W-1:0]  stop_limit;

  // tachometer state
  logic [TIMESTAMP_BITS-1:0] last_edge_left;
  logic [TIMESTAMP_BITS-1:0] last_edge_right;
  logic [PERIOD_W-1:0]       period_left;
  logic [PERIOD_W-1:0]       period_right;

  // sequencer
  state_t               state;
  state_t               state_next;
  logic                 chan;        // 0 left wheel, 1 right wheel
  logic [DIVISOR_W-1:0] divisor;
  logic                 qual;        // period in the running range
  logic [SPEED_W-1:0]   speed_l;
  logic [SPEED_W-1:0]   speed_r;

  div_req_t div_ctl;
  div_rsp_t div_stat;

  logic                      req_acc;
  logic                      cfg_wr;
  logic                      out_load;
  logic [EXT_W-1:0]          now_ext;
  logic [TIMESTAMP_BITS-1:0] now_ts;
  logic [TIMESTAMP_BITS-1:0] elapsed_left;
  logic [TIMESTAMP_BITS-1:0] elapsed_right;
  logic [PERIOD_W-1:0]       period_cur;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign req_acc = req.valid & req.ready;

  // timestamp reduced to TIMESTAMP_BITS, elapsed time wraps at that width
  assign now_ext       = EXT_W'(req.now);
  assign now_ts        = now_ext[TIMESTAMP_BITS-1:0];
  assign elapsed_left  = now_ts - last_edge_left;
  assign elapsed_right = now_ts - last_edge_right;

  assign period_cur = chan ? period_right : period_left;
  assign out_load   = ~rsp.valid | rsp.ready;

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_NUM:   prdata = APB_DW'(speed_numerator);
      REG_TEETH: prdata = APB_DW'(teeth_per_rev);
      REG_STOP:  prdata = APB_DW'(stop_limit);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and strobes
  always_comb begin
    state_next       = state;
    div_ctl.start    = 1'b0;
    div_ctl.dividend = speed_numerator;
    div_ctl.divisor  = divisor;
    unique case (state)
      ST_IDLE: begin
        if (req_acc && req.cmd == CMD_SPEED) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_START;
      end
      ST_START: begin
        if (qual) begin
          div_ctl.start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = chan ? ST_OUT : ST_MUL;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = chan ? ST_OUT : ST_MUL;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_numerator <= NUM_RESET;
      teeth_per_rev   <= TEETH_RESET;
      stop_limit      <= STOP_RESET;
      last_edge_left  <= '0;
      last_edge_right <= '0;
      period_left     <= '0;
      period_right    <= '0;
      rsp.valid       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_NUM:   speed_numerator <= pwdata[NUM_W-1:0];
          REG_TEETH: teeth_per_rev   <= pwdata[TEETH_W-1:0];
          REG_STOP:  stop_limit      <= pwdata[STOP_W-1:0];
          default:   ;
        endcase
      end

      if (req_acc) begin
        case (req.cmd)
          CMD_LEFT: begin
            period_left    <= elapsed_left[PERIOD_W-1:0];
            last_edge_left <= now_ts;
          end
          CMD_RIGHT: begin
            period_right    <= elapsed_right[PERIOD_W-1:0];
            last_edge_right <= now_ts;
          end
          default: ;
        endcase
      end

      if (state == ST_OUT && out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (req_acc) begin
      chan <= 1'b0;
    end
    if (state == ST_MUL) begin
      divisor <= DIVISOR_W'(teeth_per_rev) * DIVISOR_W'(period_cur);
      qual    <= (period_cur != '0) && (period_cur < stop_limit);
    end
    // stopped or zero period reads as zero speed
    if (state == ST_START && !qual) begin
      if (chan) begin
        speed_r <= '0;
      end else begin
        speed_l <= '0;
      end
      chan <= 1'b1;
    end
    if (state == ST_DIV && div_stat.done) begin
      if (chan) begin
        speed_r <= div_stat.quot;
      end else begin
        speed_l <= div_stat.quot;
      end
      chan <= 1'b1;
    end
    if (state == ST_OUT && out_load) begin
      rsp.speed_left  <= speed_l;
      rsp.speed_right <= speed_r;
    end
  end

  dwsp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (div_ctl),
    .stat (div_stat)
  );

endmodule

@@ hdl/dwsp_checker.sv @@
`include "dual_wheel_speed_period_meter_top_defines.svh"

module dwsp_props (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic [dwsp_pkg::CMD_W-1:0] req_cmd,
  input logic                       rsp_valid,
  input logic                       rsp_ready
);
  import dwsp_pkg::*;

  logic acc_speed;
  logic acc_other;

  assign acc_speed = req_valid && req_ready && (req_cmd == CMD_SPEED);
  assign acc_other = req_valid && req_ready && (req_cmd != CMD_SPEED);

  // a pending result is never dropped
  `DWSP_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)

  // a speed request keeps the block busy through multiply and divider start
  `DWSP_ASSERT_NEXT(a_speed_busy, clk, rst, acc_speed, !req_ready ##1 !req_ready)

  // edge and unused commands leave the block ready again in the next cycle
  `DWSP_ASSERT_NEXT(a_edge_fast, clk, rst, acc_other, req_ready)

  // reset leaves no result pending
  `DWSP_ASSERT_ALWAYS(a_rst_clear, clk, $past(rst), !rsp_valid)

endmodule

bind dual_wheel_speed_period_meter_top dwsp_props u_dwsp_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_cmd   (req.cmd),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready)
);
